@@ src/tppc_pkg.sv @@
// Shared types and constants for the trajectory point plausibility check.
// Widths, state enums, engine request/response structs.
// No dependencies.
package tppc_pkg;

  localparam int unsigned CoordW    = 30;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned DtW       = TimeW + 1;
  localparam int unsigned SumW      = 62;
  localparam int unsigned RootW     = SumW / 2 + 0;
  localparam int unsigned RemW      = 33;
  localparam int unsigned CsW       = RemW + 2;
  localparam int unsigned MulW      = 32;
  localparam int unsigned ProdW     = 2 * MulW;
  localparam int unsigned DvdW      = 40;
  localparam int unsigned SpeedW    = 24;
  localparam int unsigned CountW    = 16;
  localparam int unsigned LimitW    = 10;
  localparam int unsigned CntW      = 6;
  localparam int unsigned RootSteps = SumW / 2;
  localparam int unsigned DivSteps  = DvdW;
  localparam int unsigned SqSteps   = 4;

  localparam int unsigned InTdataW  = 128;
  localparam int unsigned OutTdataW = 112;
  localparam int unsigned OutTuserW = 5;

  localparam logic [MulW-1:0]   SpeedFactor = MulW'(360);
  localparam logic [6:0]        LimitScale  = 7'd100;
  localparam logic [LimitW-1:0] LimitReset  = LimitW'(80);
  localparam logic [SpeedW-1:0] SpeedMax    = '1;
  localparam logic [CountW-1:0] CountMax    = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_CALC,
    ST_FINISH
  } ctl_state_e;

  typedef enum logic [2:0] {
    EN_IDLE,
    EN_SQUARE,
    EN_ROOT,
    EN_SCALE,
    EN_LOAD,
    EN_DIVIDE,
    EN_DONE
  } eng_state_e;

  typedef struct packed {
    logic              start;
    logic [CoordW-1:0] dx;
    logic [CoordW-1:0] dy;
    logic [CoordW-1:0] dz;
    logic [TimeW-1:0]  dt;
  } eng_req_t;

  typedef struct packed {
    logic              done;
    logic [SpeedW-1:0] speed;
  } eng_rsp_t;

endpackage

@@ src/trajectory_point_plausibility_check.sv @@
// Top level of the trajectory point plausibility check: stream ports, history,
// fault flags, counters and peak speed. Depends on tppc_pkg and tppc_engine.
//
// One request is one trajectory point (time in ms, x/y/z in mm). The block compares it
// with the previous point and returns one result per request. For a point that forms a
// pair the block hands the differences to the engine, which forms the squares on its
// multiplier, takes 31 compare-subtract steps of the square root, scales by 360,
// takes 40 steps of the restoring divide and hands over the quotient; then the result
// is loaded. A point without a pair (first point or start mark) skips the engine.
// s_axis_tready_o is low while a point is being worked on and while its result waits
// for the output register to be taken.
module trajectory_point_plausibility_check import tppc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // time_ms[31:0], x_mm[61:32], y_mm[91:62], z_mm[121:92], zero pad
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // start_trajectory[0]
  input  logic [0:0]           s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // pair_speed[23:0], count_over_limit[39:24], count_coincident[55:40],
  // count_backward[71:56], count_instant[87:72], highest_speed[111:88]
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // pair_valid[0], coincident[1], time_backward[2], instant_jump[3], over_limit[4]
  output logic [OutTuserW-1:0] m_axis_tuser_o,
  input  logic                 cfg_we_i,
  input  logic [LimitW-1:0]    cfg_wdata_i
);

  function automatic logic [CoordW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
    logic [CoordW:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    return d[CoordW] ? CoordW'(~d + 1'b1) : d[CoordW-1:0];
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

  ctl_state_e state_q, state_d;

  logic [LimitW-1:0] limit_q;

  logic              in_start_q;
  logic [TimeW-1:0]  in_time_q;
  logic [CoordW-1:0] in_x_q, in_y_q, in_z_q;

  logic              have_prev_q;
  logic [TimeW-1:0]  prev_time_q;
  logic [CoordW-1:0] prev_x_q, prev_y_q, prev_z_q;

  logic              pair_q;
  logic [CoordW-1:0] dx_q, dy_q, dz_q;
  logic [DtW-1:0]    dt_q;
  logic [SpeedW-1:0] speed_q;

  logic [CountW-1:0] cnt_over_q, cnt_coin_q, cnt_back_q, cnt_inst_q;
  logic [SpeedW-1:0] peak_q;

  logic                 m_tvalid_q;
  logic [OutTdataW-1:0] m_tdata_q;
  logic [OutTuserW-1:0] m_tuser_q;

  eng_req_t eng_req;
  eng_rsp_t eng_rsp;

  logic              in_acc, pair_new, out_free, out_load;
  logic              f_coin, f_back, f_inst, f_over, spd_ok, dt_zero, pos_same;
  logic [SpeedW-1:0] f_speed, limit_ext;
  logic [CountW-1:0] cnt_over_d, cnt_coin_d, cnt_back_d, cnt_inst_d;
  logic [SpeedW-1:0] peak_d;

  tppc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (eng_req),
    .rsp_o  (eng_rsp)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign pair_new        = have_prev_q & ~in_start_q;
  assign out_free        = ~m_tvalid_q | m_axis_tready_i;

  assign eng_req.start = (state_q == ST_DIFF) & pair_new;
  assign eng_req.dx    = dx_q;
  assign eng_req.dy    = dy_q;
  assign eng_req.dz    = dz_q;
  assign eng_req.dt    = dt_q[TimeW-1:0];

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_d = pair_new ? ST_CALC : ST_FINISH;
      end
      ST_CALC: begin
        if (eng_rsp.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // pair evaluation, valid in ST_FINISH
  assign pos_same  = (dx_q == '0) & (dy_q == '0) & (dz_q == '0);
  assign dt_zero   = (dt_q == '0);
  assign f_coin    = pair_q & pos_same;
  assign f_back    = pair_q & dt_q[DtW-1];
  assign f_inst    = pair_q & dt_zero & ~pos_same;
  assign spd_ok    = pair_q & ~dt_q[DtW-1] & ~dt_zero & ~pos_same;
  assign f_speed   = spd_ok ? speed_q : '0;
  assign limit_ext = SpeedW'(limit_q) * SpeedW'(LimitScale);
  assign f_over    = spd_ok & (f_speed > limit_ext);

  assign cnt_over_d = f_over ? sat_inc(cnt_over_q) : cnt_over_q;
  assign cnt_coin_d = f_coin ? sat_inc(cnt_coin_q) : cnt_coin_q;
  assign cnt_back_d = f_back ? sat_inc(cnt_back_q) : cnt_back_q;
  assign cnt_inst_d = f_inst ? sat_inc(cnt_inst_q) : cnt_inst_q;
  assign peak_d     = (f_speed > peak_q) ? f_speed : peak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= LimitReset;
      have_prev_q <= 1'b0;
      cnt_over_q  <= '0;
      cnt_coin_q  <= '0;
      cnt_back_q  <= '0;
      cnt_inst_q  <= '0;
      peak_q      <= '0;
      m_tvalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (state_q == ST_DIFF) begin
        have_prev_q <= 1'b1;
        if (in_start_q) begin
          cnt_over_q <= '0;
          cnt_coin_q <= '0;
          cnt_back_q <= '0;
          cnt_inst_q <= '0;
          peak_q     <= '0;
        end
      end
      if (out_load) begin
        cnt_over_q <= cnt_over_d;
        cnt_coin_q <= cnt_coin_d;
        cnt_back_q <= cnt_back_d;
        cnt_inst_q <= cnt_inst_d;
        peak_q     <= peak_d;
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_start_q <= s_axis_tuser_i[0];
      in_time_q  <= s_axis_tdata_i[TimeW-1:0];
      in_x_q     <= s_axis_tdata_i[TimeW +: CoordW];
      in_y_q     <= s_axis_tdata_i[TimeW + CoordW +: CoordW];
      in_z_q     <= s_axis_tdata_i[TimeW + 2*CoordW +: CoordW];
    end
    if (state_q == ST_DIFF) begin
      pair_q      <= pair_new;
      dx_q        <= abs_diff(in_x_q, prev_x_q);
      dy_q        <= abs_diff(in_y_q, prev_y_q);
      dz_q        <= abs_diff(in_z_q, prev_z_q);
      dt_q        <= {in_time_q[TimeW-1], in_time_q} - {prev_time_q[TimeW-1], prev_time_q};
      speed_q     <= '0;
      prev_time_q <= in_time_q;
      prev_x_q    <= in_x_q;
      prev_y_q    <= in_y_q;
      prev_z_q    <= in_z_q;
    end
    if ((state_q == ST_CALC) && eng_rsp.done) begin
      speed_q <= eng_rsp.speed;
    end
    if (out_load) begin
      m_tdata_q <= {peak_d, cnt_inst_d, cnt_back_d, cnt_coin_d, cnt_over_d, f_speed};
      m_tuser_q <= {f_over, f_inst, f_back, f_coin, pair_q};
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_rsp.done |-> (state_q == ST_CALC))
    else $error("engine finished outside calculation phase");

  a_accept_to_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == ST_DIFF))
    else $error("accepted request did not enter difference phase");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_tdata_q[OutTdataW-1 -: SpeedW] >= m_tdata_q[SpeedW-1:0]))
    else $error("highest speed below pair speed");

  a_over_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_tuser_q[4]) |->
      (m_tuser_q[0] && !m_tuser_q[1] && !m_tuser_q[2] && !m_tuser_q[3]))
    else $error("over limit flagged on a pair without speed");

endmodule

@@ src/tppc_mul.sv @@
// Shared multiplier with registered product.
// Depends on tppc_pkg.
module tppc_mul import tppc_pkg::*; (
  input  logic             clk_i,
  input  logic [MulW-1:0]  a_i,
  input  logic [MulW-1:0]  b_i,
  output logic [ProdW-1:0] p_o
);

  logic [ProdW-1:0] p_q, p_d;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

@@ src/tppc_cmpsub.sv @@
// Shared compare-and-subtract unit for the root and divide steps.
// Depends on tppc_pkg.
module tppc_cmpsub import tppc_pkg::*; (
  input  logic [CsW-1:0] a_i,
  input  logic [CsW-1:0] b_i,
  output logic           ge_o,
  output logic [CsW-1:0] diff_o
);

  logic borrow;

  assign {borrow, diff_o} = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o = ~borrow;

endmodule

@@ src/tppc_engine.sv @@
// Speed engine: sum of squares, digit-by-digit square root, scale, restoring divide.
// Depends on tppc_pkg, tppc_mul, tppc_cmpsub.
module tppc_engine import tppc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  eng_req_t req_i,
  output eng_rsp_t rsp_o
);

  eng_state_e       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SumW-1:0]  acc_q, acc_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;

  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] prod;
  logic [CsW-1:0]   cs_a, cs_b, cs_diff;
  logic             cs_ge;

  tppc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  tppc_cmpsub u_cmpsub (
    .a_i    (cs_a),
    .b_i    (cs_b),
    .ge_o   (cs_ge),
    .diff_o (cs_diff)
  );

  always_comb begin
    if (state_q == EN_SCALE) begin
      mul_a = MulW'(root_q);
      mul_b = SpeedFactor;
    end else begin
      unique case (cnt_q[1:0])
        2'd0:    mul_a = MulW'(req_i.dx);
        2'd1:    mul_a = MulW'(req_i.dy);
        default: mul_a = MulW'(req_i.dz);
      endcase
      mul_b = mul_a;
    end
  end

  always_comb begin
    if (state_q == EN_DIVIDE) begin
      cs_a = CsW'({rem_q[RemW-2:0], acc_q[SumW-1]});
      cs_b = CsW'(req_i.dt);
    end else begin
      cs_a = {rem_q, acc_q[SumW-1 -: 2]};
      cs_b = CsW'({root_q, 2'b01});
    end
  end

  assign rsp_o.done  = (state_q == EN_DONE);
  assign rsp_o.speed = (|acc_q[DvdW-1:SpeedW]) ? SpeedMax : acc_q[SpeedW-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    unique case (state_q)
      EN_IDLE: begin
        if (req_i.start) begin
          acc_d   = '0;
          cnt_d   = '0;
          state_d = EN_SQUARE;
        end
      end
      EN_SQUARE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          acc_d = acc_q + SumW'(prod[2*CoordW-1:0]);
        end
        if (cnt_q == CntW'(SqSteps - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          root_d  = '0;
          state_d = EN_ROOT;
        end
      end
      EN_ROOT: begin
        acc_d = {acc_q[SumW-3:0], 2'b00};
        if (cs_ge) begin
          rem_d  = cs_diff[RemW-1:0];
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = cs_a[RemW-1:0];
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(RootSteps - 1)) begin
          state_d = EN_SCALE;
        end
      end
      EN_SCALE: begin
        state_d = EN_LOAD;
      end
      EN_LOAD: begin
        acc_d   = {prod[DvdW-1:0], (SumW - DvdW)'(0)};
        rem_d   = '0;
        cnt_d   = '0;
        state_d = EN_DIVIDE;
      end
      EN_DIVIDE: begin
        acc_d = {acc_q[SumW-2:0], cs_ge};
        rem_d = cs_ge ? cs_diff[RemW-1:0] : cs_a[RemW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = EN_DONE;
        end
      end
      EN_DONE: begin
        state_d = EN_IDLE;
      end
      default: begin
        state_d = EN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EN_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

endmodule

@@ dv/tb_trajectory_point_plausibility_check.sv @@
// Testbench for trajectory_point_plausibility_check: directed corner points,
// limit extremes and random trajectories, checked against an in-bench predictor.
// Depends on tppc_pkg and the block's RTL.
module tb_trajectory_point_plausibility_check;
  import tppc_pkg::*;

  localparam int CoordMin = -536870912;
  localparam int CoordMax = 536870911;
  localparam int TimeMin  = 32'sh8000_0000;
  localparam int TimeMax  = 32'sh7fff_ffff;

  typedef struct {
    bit                       start;
    logic signed [TimeW-1:0]  t;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    logic              pair_valid;
    logic              coincident;
    logic              time_backward;
    logic              instant_jump;
    logic              over_limit;
    logic [SpeedW-1:0] pair_speed;
    logic [CountW-1:0] n_over;
    logic [CountW-1:0] n_coincident;
    logic [CountW-1:0] n_backward;
    logic [CountW-1:0] n_instant;
    logic [SpeedW-1:0] highest;
  } verdict_t;

  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_SLOTTED} rx_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i = '0;
  logic [0:0]           s_axis_tuser_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic [OutTuserW-1:0] m_axis_tuser_o;
  logic                 cfg_we_i = 1'b0;
  logic [LimitW-1:0]    cfg_wdata_i = '0;

  trajectory_point_plausibility_check uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [LimitW-1:0]        limit_kmh = LimitReset;
  bit                       has_last;
  logic signed [TimeW-1:0]  last_t;
  logic signed [CoordW-1:0] last_x, last_y, last_z;
  logic [CountW-1:0]        tally_over = '0;
  logic [CountW-1:0]        tally_coincident = '0;
  logic [CountW-1:0]        tally_backward = '0;
  logic [CountW-1:0]        tally_instant = '0;
  logic [SpeedW-1:0]        peak = '0;

  verdict_t pending_verdicts[$];
  int       mismatches;
  int       burst_left;

  // trajectory generator position
  int cur_t, cur_x, cur_y, cur_z;

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [CountW-1:0] bump(logic [CountW-1:0] c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

  function automatic verdict_t judge_point(point_t p);
    verdict_t v;
    longint dx, dy, dz, dt;
    longint unsigned ssq, q;
    v = '0;
    if (p.start) begin
      has_last = 1'b0;
      tally_over = '0;
      tally_coincident = '0;
      tally_backward = '0;
      tally_instant = '0;
      peak = '0;
    end
    if (has_last) begin
      dx = longint'(p.x) - longint'(last_x);
      dy = longint'(p.y) - longint'(last_y);
      dz = longint'(p.z) - longint'(last_z);
      dt = longint'(p.t) - longint'(last_t);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      ssq = dx * dx + dy * dy + dz * dz;
      v.pair_valid = 1'b1;
      if (ssq == 0) begin
        v.coincident = 1'b1;
        tally_coincident = bump(tally_coincident);
      end
      if (dt < 0) begin
        v.time_backward = 1'b1;
        tally_backward = bump(tally_backward);
      end
      if (dt == 0 && ssq != 0) begin
        v.instant_jump = 1'b1;
        tally_instant = bump(tally_instant);
      end
      if (dt > 0 && ssq != 0) begin
        q = (64'd360 * floor_root(ssq)) / longint'(dt);
        v.pair_speed = (q > SpeedMax) ? SpeedMax : q[SpeedW-1:0];
        if (v.pair_speed > peak) peak = v.pair_speed;
        if (longint'(v.pair_speed) > longint'(limit_kmh) * LimitScale) begin
          v.over_limit = 1'b1;
          tally_over = bump(tally_over);
        end
      end
    end
    has_last = 1'b1;
    last_t = p.t;
    last_x = p.x;
    last_y = p.y;
    last_z = p.z;
    v.n_over = tally_over;
    v.n_coincident = tally_coincident;
    v.n_backward = tally_backward;
    v.n_instant = tally_instant;
    v.highest = peak;
    return v;
  endfunction

  function automatic point_t mk_point(bit s, int t, int x, int y, int z);
    point_t p;
    p.start = s;
    p.t = t;
    p.x = CoordW'(x);
    p.y = CoordW'(y);
    p.z = CoordW'(z);
    return p;
  endfunction

  // sender: bursts of random length, random gaps in between
  task automatic send_point(point_t p);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= InTdataW'({p.z, p.y, p.x, p.t});
    s_axis_tuser_i  <= p.start;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_verdicts.push_back(judge_point(p));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_speed_limit(logic [LimitW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_kmh = v;
  endtask

  // receiver stall pattern
  rx_mode_e rx_mode = RX_FREE;
  int       rx_left;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:   m_axis_tready_i <= 1'b1;
      RX_COIN:   m_axis_tready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready_i <= ((rx_left % 40) < 8);
    endcase
  end

  task automatic note_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      if (mismatches < 10)
        $display("%0t: %s expected %0d got %0d", $realtime, name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    verdict_t exp, got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.pair_valid    = m_axis_tuser_o[0];
      got.coincident    = m_axis_tuser_o[1];
      got.time_backward = m_axis_tuser_o[2];
      got.instant_jump  = m_axis_tuser_o[3];
      got.over_limit    = m_axis_tuser_o[4];
      got.pair_speed    = m_axis_tdata_o[23:0];
      got.n_over        = m_axis_tdata_o[39:24];
      got.n_coincident  = m_axis_tdata_o[55:40];
      got.n_backward    = m_axis_tdata_o[71:56];
      got.n_instant     = m_axis_tdata_o[87:72];
      got.highest       = m_axis_tdata_o[111:88];
      if (pending_verdicts.size() == 0) begin
        if (mismatches < 10) $display("%0t: result with no request outstanding", $realtime);
        mismatches++;
      end else begin
        exp = pending_verdicts.pop_front();
        note_field("pair_valid", exp.pair_valid, got.pair_valid);
        note_field("coincident", exp.coincident, got.coincident);
        note_field("time_backward", exp.time_backward, got.time_backward);
        note_field("instant_jump", exp.instant_jump, got.instant_jump);
        note_field("over_limit", exp.over_limit, got.over_limit);
        note_field("pair_speed", exp.pair_speed, got.pair_speed);
        note_field("count_over_limit", exp.n_over, got.n_over);
        note_field("count_coincident", exp.n_coincident, got.n_coincident);
        note_field("count_backward", exp.n_backward, got.n_backward);
        note_field("count_instant", exp.n_instant, got.n_instant);
        note_field("highest_speed", exp.highest, got.highest);
      end
    end
  end

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly plausible trajectories near the limit, with faults and noise mixed in
  task automatic run_trajectories(int n_items);
    int sent, len, kind, dt, span, dx, dy, dz;
    bit s;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(2, 30);
      for (int i = 0; i < len && sent < n_items; i++) begin
        s = 1'b0;
        if (i == 0) begin
          s = ($urandom_range(0, 9) != 0);
          cur_t = $urandom;
          if ($urandom_range(0, 2) == 0) begin
            cur_x = $urandom;
            cur_y = $urandom;
            cur_z = $urandom;
          end else begin
            cur_x = spread(1 << 20);
            cur_y = spread(1 << 20);
            cur_z = spread(1 << 20);
          end
        end else begin
          kind = $urandom_range(0, 99);
          dt = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2000);
          span = dt * $urandom_range(0, 60);
          dx = spread(span);
          dy = spread(span);
          dz = spread(span);
          if (kind < 70) begin
          end else if (kind < 77) begin
            dx = 0;
            dy = 0;
            dz = 0;
            if ($urandom_range(0, 3) == 0) dt = -int'($urandom_range(1, 50));
          end else if (kind < 83) begin
            dt = -int'($urandom_range(1, 5000));
          end else if (kind < 88) begin
            dt = 0;
          end else if (kind < 94) begin
            dx = $urandom;
            dy = $urandom;
            dz = $urandom;
          end else begin
            s = 1'($urandom_range(0, 1));
            dt = $urandom;
            dx = $urandom;
            dy = $urandom;
            dz = $urandom;
          end
          cur_t = cur_t + dt;
          cur_x = cur_x + dx;
          cur_y = cur_y + dy;
          cur_z = cur_z + dz;
        end
        send_point(mk_point(s, cur_t, cur_x, cur_y, cur_z));
        sent++;
      end
    end
  endtask

  task automatic test_directed_cases();
    send_point(mk_point(0, 100, 0, 0, 0));      // no previous point
    send_point(mk_point(0, 100, 0, 0, 0));      // coincident, zero dt
    send_point(mk_point(0, 50, 0, 0, 0));       // coincident and backward
    send_point(mk_point(0, 50, 5, 0, 0));       // jump in zero time
    send_point(mk_point(0, 59, 205, 0, 0));     // exactly at limit
    send_point(mk_point(0, 68, 406, 0, 0));     // just above
    send_point(mk_point(0, 69, 409, 4, 0));
    send_point(mk_point(0, 70, 410, 5, 0));
    send_point(mk_point(0, 71, 410, 5, 1));
    send_point(mk_point(1, TimeMin, CoordMin, CoordMin, CoordMin));
    send_point(mk_point(0, TimeMax, CoordMax, CoordMax, CoordMax));
    send_point(mk_point(0, TimeMin, CoordMin, CoordMin, CoordMin));
    send_point(mk_point(0, TimeMin + 1, CoordMax, CoordMin, CoordMax));
    send_point(mk_point(0, TimeMin + 2, CoordMax, CoordMin, CoordMax));
    send_point(mk_point(1, 0, 0, 0, 0));
    send_point(mk_point(1, 0, 0, 0, 0));        // back-to-back start marks
    send_point(mk_point(0, 1, 0, CoordMax, 0)); // saturated speed
    send_point(mk_point(0, 2, 0, CoordMax, CoordMin));
    send_point(mk_point(0, 1, -1, -1, -1));
    send_point(mk_point(1, -1, 7, -7, 7));
    send_point(mk_point(0, 3599, 1007, -7, 7));
  endtask

  task automatic test_limit_extremes();
    logic [LimitW-1:0] limits[4] = '{'0, '1, 1, 1000};
    foreach (limits[i]) begin
      set_speed_limit(limits[i]);
      run_trajectories(25);
    end
  endtask

  task automatic test_random_trajectories();
    for (int phase = 0; phase < 6; phase++) begin
      set_speed_limit($urandom_range(1, 1000));
      run_trajectories(210);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_limit_extremes();
    test_random_trajectories();
    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0)
      $display("trajectory_point_plausibility_check: match");
    else
      $display("trajectory_point_plausibility_check: mismatch");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("trajectory_point_plausibility_check: mismatch");
    $finish;
  end

endmodule
